[hw/rtl/mp2_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_pkg: shared types and constants for the 2x2 max-pool stream
// Sizes, register indexes and the command format passed from front to back.
// ----------------------------------------------------------------------------
package mp2_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int DIM_BITS   = 11;                  // width of a dimension register
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_BITS   = $clog2(LINE_DEPTH);

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HEIGHT = 2'd1;

  localparam logic [DIM_BITS-1:0] DIM_MIN        = 11'd2;
  localparam logic [DIM_BITS-1:0] DIM_RESET      = 11'd4;
  localparam logic [DIM_BITS-1:0] WIDTH_LIMIT    = DIM_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0] HEIGHT_LIMIT   = DIM_BITS'(MAX_HEIGHT);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,   // left sample of a pair: hold it
    OP_WRITE = 2'd1,   // even row pair: store pair max in line
    OP_READ  = 2'd2    // odd row pair: combine with line, emit result
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [IDX_BITS-1:0] idx;
    sample_t             sample;
    logic                last;
  } cmd_t;

  function automatic sample_t larger(sample_t a, sample_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [DIM_BITS-1:0] clamp_dim(logic [DIM_BITS-1:0] value,
                                                     logic [DIM_BITS-1:0] top);
    if (value < DIM_MIN) return DIM_MIN;
    if (value > top)     return top;
    return value;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mp2_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module mp2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mp2_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_front: frame position tracking and sample classification
// Holds the dimension registers and counters, tags each kept sample.
// ----------------------------------------------------------------------------
module mp2_front
  import mp2_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0]       cfg_data,
  input  wire logic                      accept,
  input  wire sample_t                   sample,
  output logic                           push,
  output cmd_t                           cmd
);

  logic [DIM_BITS-1:0] map_width_r, map_height_r;
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic [DIM_BITS-1:0] used_w, used_h;
  logic [DIM_BITS-1:0] col_ext, row_ext;
  logic [DIM_BITS-1:0] col_inc, row_inc;
  logic                in_window;

  assign used_w  = {map_width_r[DIM_BITS-1:1], 1'b0};
  assign used_h  = {map_height_r[DIM_BITS-1:1], 1'b0};
  assign col_ext = DIM_BITS'(col_r);
  assign row_ext = DIM_BITS'(row_r);
  assign col_inc = col_ext + 1'b1;
  assign row_inc = row_ext + 1'b1;

  assign in_window = (col_ext < used_w) && (row_ext < used_h);

  always_comb begin
    col_nxt = col_inc[COL_BITS-1:0];
    row_nxt = row_r;
    if (col_inc >= map_width_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= map_height_r) ? '0 : row_inc[ROW_BITS-1:0];
    end
  end

  always_comb begin
    cmd.idx    = col_r[COL_BITS-1:1];
    cmd.sample = sample;
    cmd.last   = (col_ext == used_w - 1'b1) && (row_ext == used_h - 1'b1);
    if (!col_r[0])      cmd.op = OP_LEFT;
    else if (!row_r[0]) cmd.op = OP_WRITE;
    else                cmd.op = OP_READ;
  end

  assign push = accept && in_window;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= DIM_RESET;
      map_height_r <= DIM_RESET;
      col_r        <= '0;
      row_r        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAP_WIDTH: begin
          map_width_r <= clamp_dim(cfg_data, WIDTH_LIMIT);
          col_r       <= '0;
          row_r       <= '0;
        end
        REG_MAP_HEIGHT: begin
          map_height_r <= clamp_dim(cfg_data, HEIGHT_LIMIT);
          col_r        <= '0;
          row_r        <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mp2_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_queue: short command queue between front and back
// Register-based FIFO, full and empty from a fill count.
// ----------------------------------------------------------------------------
module mp2_queue
  import mp2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                      entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_BITS:0]   count_r;

  assign full       = (count_r == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mp2_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_back: pair reduction, line store and window maximum
// Two stages: line read plus pair max, then final max into output register.
// ----------------------------------------------------------------------------
module mp2_back
  import mp2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire cmd_t head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output sample_t   out_pooled_value,
  output logic      out_last_of_frame
);

  sample_t held_r;
  sample_t pair_max;
  logic    s1_valid_r;
  sample_t s1_pm_r;
  logic    s1_last_r;
  logic    out_valid_r;
  sample_t out_value_r;
  logic    out_last_r;
  logic    adv, pop_ok;
  logic    is_write, is_read;
  logic [SAMPLE_BITS-1:0] line_q;

  assign adv      = !out_valid_r || !out_stall;
  assign pop_ok   = !s1_valid_r || adv;
  assign pop      = head_valid && pop_ok;
  assign pair_max = larger(held_r, head_cmd.sample);
  assign is_write = pop && (head_cmd.op == OP_WRITE);
  assign is_read  = pop && (head_cmd.op == OP_READ);

  mp2_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (is_write),
    .wr_addr (head_cmd.idx),
    .wr_data (pair_max),
    .rd_en   (is_read),
    .rd_addr (head_cmd.idx),
    .rd_data (line_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (pop && (head_cmd.op == OP_LEFT)) begin
      held_r <= head_cmd.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_ok) s1_valid_r  <= is_read;
      if (adv)    out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      s1_pm_r   <= pair_max;
      s1_last_r <= head_cmd.last;
    end
    if (adv && s1_valid_r) begin
      out_value_r <= larger(sample_t'(line_q), s1_pm_r);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pooled_value  = out_value_r;
  assign out_last_of_frame = out_last_r;

endmodule
`default_nettype wire

[hw/rtl/max_pool_2x2_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: window's bottom-right beat -> queue slot -> line read -> final max reg.
// Throughput: one input beat per cycle while the queue is not full, limited
//   by the single line RAM port pair (one write, one read per cycle);
//   out_stall backs up through the queue.
// Reset: synchronous active-low rst_n clears counters, queue and pipeline and
//   sets map_width = map_height = 4; the line RAM is not cleared.
// ----------------------------------------------------------------------------
// max_pool_2x2_stream: 2x2 stride-2 max pooling on a raster sample stream
// Front tracks position and tags samples, a 4-deep queue decouples it from the
// back end, which holds the left sample, keeps even-row pair maxima in a line
// RAM and combines them with odd-row pairs into one result per window.
// ----------------------------------------------------------------------------
module max_pool_2x2_stream
  import mp2_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // sample input
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire sample_t                   in_sample,
  // pooled output
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output sample_t                        out_pooled_value,
  output logic                           out_last_of_frame,
  // configuration write
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0]       cfg_data
);

  logic accept;
  logic push, q_full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  // Config writes always taken; user must keep to block idle, not enforced.
  assign cfg_ready = 1'b1;

  // Stall only on a full queue, so the front keeps moving while the back
  // end waits on a stalled output beat.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mp2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (in_sample),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Dropped-edge samples (odd last column or row) never enter the queue.
  mp2_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mp2_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_cmd          (head_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pooled_value  (out_pooled_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
`default_nettype wire
